// File: sv/hsl2rgb_pkg.sv
// Shared constants, types and helpers for the HSL to RGB converter.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CH_W      = 8;
   localparam int FX_W      = FRAC_BITS + 1;
   localparam int QW        = FX_W + 1;
   localparam int FACT_W    = FX_W;
   localparam int PROD_W    = QW + FACT_W;
   localparam int V_W       = QW + 1;
   localparam int STAGES    = 6;

   localparam int ONE_INT   = 2 ** FRAC_BITS;
   localparam int FIX_K     = ONE_INT / 255;
   localparam int FIX_R     = ONE_INT % 255;

   localparam logic [FX_W-1:0] FX_ONE        = FX_W'(ONE_INT);
   localparam logic [FX_W-1:0] FX_HALF       = FX_W'(ONE_INT / 2);
   localparam logic [FX_W-1:0] FX_THIRD      = FX_W'(ONE_INT / 3);
   localparam logic [FX_W-1:0] FX_SIXTH      = FX_W'(ONE_INT / 6);
   localparam logic [FX_W-1:0] FX_TWO_THIRDS = FX_W'((2 * ONE_INT) / 3);

   typedef struct packed {
      logic s6;
      logic s5;
      logic s4;
      logic s3;
      logic s2;
      logic s1;
   } hsl2rgb_en_type;

   // floor(v * ONE / 255) as v * K + floor(v * R / 255), the second term by reciprocal
   function automatic logic [FX_W-1:0] to_fixed(input logic [CH_W-1:0] v);
      logic [FX_W+CH_W-1:0] base;
      logic [2*CH_W:0]      rem_x;
      logic [2*CH_W:0]      rem_q;
      base  = (FX_W + CH_W)'(v) * (FX_W + CH_W)'(FIX_K);
      rem_x = (2 * CH_W + 1)'(v) * (2 * CH_W + 1)'(FIX_R);
      rem_q = (rem_x + (rem_x >> CH_W) + (2 * CH_W + 1)'(1)) >> CH_W;
      return FX_W'(base + (FX_W + CH_W)'(rem_q));
   endfunction

endpackage

// File: sv/hsl2rgb_ctrl.sv
// Valid tracking and per-stage load enables for the converter pipeline.
`timescale 1ns / 1ps

module hsl2rgb_ctrl import hsl2rgb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output hsl2rgb_en_type en
);

   logic [STAGES:1]   valid_ff;
   logic [STAGES:1]   valid_in;
   logic [STAGES+1:1] adv;

   always_comb begin
      adv[STAGES+1] = !rsp_stall;
      for (int k = STAGES; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = adv[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign en        = hsl2rgb_en_type'(adv[STAGES:1]);
   assign req_stall = !adv[1];
   assign rsp_valid = valid_ff[STAGES];

endmodule

// File: sv/hsl2rgb_front.sv
// Front stages: fixed-point conversion, p and q intermediates, hue positions.
`timescale 1ns / 1ps

module hsl2rgb_front import hsl2rgb_pkg::*; (
   input  logic             clock,
   input  hsl2rgb_en_type   en,
   input  logic [CH_W-1:0]  req_hue,
   input  logic [CH_W-1:0]  req_saturation,
   input  logic [CH_W-1:0]  req_lightness,
   output logic [QW-1:0]    p_out,
   output logic [QW-1:0]    d_out,
   output logic [FX_W-1:0]  t_red,
   output logic [FX_W-1:0]  t_green,
   output logic [FX_W-1:0]  t_blue,
   output logic             grey_out,
   output logic [CH_W-1:0]  light_out
);

   logic [FX_W-1:0]   hf1_ff, sf1_ff, lf1_ff;
   logic              grey1_ff;
   logic [CH_W-1:0]   l8_1_ff;

   logic [2*FX_W-1:0] ls_prod;
   logic [QW-1:0]     tr_sum;
   logic [FX_W-1:0]   m_in, tr_in, tb_in;
   logic [FX_W-1:0]   m2_ff, lf2_ff, sf2_ff, tr2_ff, tg2_ff, tb2_ff;
   logic              grey2_ff;
   logic [CH_W-1:0]   l8_2_ff;

   logic [QW-1:0]     q_raw, two_l, p_raw, q_clip, d_in;
   logic [QW-1:0]     p3_ff, d3_ff;
   logic [FX_W-1:0]   tr3_ff, tg3_ff, tb3_ff;
   logic              grey3_ff;
   logic [CH_W-1:0]   l8_3_ff;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         hf1_ff   <= to_fixed(req_hue);
         sf1_ff   <= to_fixed(req_saturation);
         lf1_ff   <= to_fixed(req_lightness);
         grey1_ff <= (req_saturation == '0);
         l8_1_ff  <= req_lightness;
      end
   end

   always_comb begin
      ls_prod = (2 * FX_W)'(lf1_ff) * (2 * FX_W)'(sf1_ff);
      m_in    = ls_prod[FRAC_BITS +: FX_W];
      tr_sum  = QW'(hf1_ff) + QW'(FX_THIRD);
      tr_in   = (tr_sum > QW'(FX_ONE)) ? FX_W'(tr_sum - QW'(FX_ONE)) : FX_W'(tr_sum);
      tb_in   = (hf1_ff < FX_THIRD) ? hf1_ff + (FX_ONE - FX_THIRD) : hf1_ff - FX_THIRD;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         m2_ff    <= m_in;
         lf2_ff   <= lf1_ff;
         sf2_ff   <= sf1_ff;
         tr2_ff   <= tr_in;
         tg2_ff   <= hf1_ff;
         tb2_ff   <= tb_in;
         grey2_ff <= grey1_ff;
         l8_2_ff  <= l8_1_ff;
      end
   end

   always_comb begin
      q_raw  = (lf2_ff < FX_HALF) ? QW'(lf2_ff) + QW'(m2_ff)
                                  : QW'(lf2_ff) + QW'(sf2_ff) - QW'(m2_ff);
      two_l  = {lf2_ff, 1'b0};
      p_raw  = (two_l > q_raw) ? two_l - q_raw : '0;
      q_clip = (q_raw < p_raw) ? p_raw : q_raw;
      d_in   = q_clip - p_raw;
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         p3_ff    <= p_raw;
         d3_ff    <= d_in;
         tr3_ff   <= tr2_ff;
         tg3_ff   <= tg2_ff;
         tb3_ff   <= tb2_ff;
         grey3_ff <= grey2_ff;
         l8_3_ff  <= l8_2_ff;
      end
   end

   assign p_out     = p3_ff;
   assign d_out     = d3_ff;
   assign t_red     = tr3_ff;
   assign t_green   = tg3_ff;
   assign t_blue    = tb3_ff;
   assign grey_out  = grey3_ff;
   assign light_out = l8_3_ff;

endmodule

// File: sv/hsl2rgb_lane.sv
// One color channel: hue ramp slope select, slope multiply, scale to 8 bits.
`timescale 1ns / 1ps

module hsl2rgb_lane import hsl2rgb_pkg::*; (
   input  logic             clock,
   input  hsl2rgb_en_type   en,
   input  logic [QW-1:0]    p_in,
   input  logic [QW-1:0]    d_in,
   input  logic [FX_W-1:0]  t_in,
   input  logic             grey_in,
   input  logic [CH_W-1:0]  light_in,
   output logic [CH_W-1:0]  ch_out
);

   logic [FX_W-1:0]    fall_t;
   logic [FX_W+2:0]    six_rise, six_fall;
   logic [FACT_W-1:0]  factor_in;

   logic [FACT_W-1:0]  factor4_ff;
   logic [QW-1:0]      p4_ff, d4_ff;
   logic               grey4_ff;
   logic [CH_W-1:0]    l4_ff;

   logic [PROD_W-1:0]  prod5_ff;
   logic [QW-1:0]      p5_ff;
   logic               grey5_ff;
   logic [CH_W-1:0]    l5_ff;

   logic [V_W-1:0]     v;
   logic [V_W+CH_W-1:0] scaled, shifted;
   logic [CH_W-1:0]    ch_clip;
   logic [CH_W-1:0]    ch_ff;

   always_comb begin
      fall_t   = FX_TWO_THIRDS - t_in;
      six_rise = {2'b0, t_in, 1'b0} + {1'b0, t_in, 2'b0};
      six_fall = {2'b0, fall_t, 1'b0} + {1'b0, fall_t, 2'b0};
      priority if (t_in < FX_SIXTH) begin
         factor_in = FACT_W'(six_rise);
      end else if (t_in < FX_HALF) begin
         factor_in = FACT_W'(FX_ONE);
      end else if (t_in < FX_TWO_THIRDS) begin
         factor_in = FACT_W'(six_fall);
      end else begin
         factor_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         factor4_ff <= factor_in;
         p4_ff      <= p_in;
         d4_ff      <= d_in;
         grey4_ff   <= grey_in;
         l4_ff      <= light_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         prod5_ff <= PROD_W'(d4_ff) * PROD_W'(factor4_ff);
         p5_ff    <= p4_ff;
         grey5_ff <= grey4_ff;
         l5_ff    <= l4_ff;
      end
   end

   always_comb begin
      v       = V_W'(p5_ff) + V_W'(prod5_ff[FRAC_BITS +: QW]);
      scaled  = {v, {CH_W{1'b0}}} - (V_W + CH_W)'(v);
      shifted = scaled >> FRAC_BITS;
      ch_clip = (shifted > (V_W + CH_W)'(255)) ? '1 : shifted[CH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.s6) begin
         ch_ff <= grey5_ff ? l5_ff : ch_clip;
      end
   end

   assign ch_out = ch_ff;

endmodule

// File: sv/hsl_to_rgb_converter.sv
// HSL to RGB converter top level: six-stage pipeline, three channel lanes.
// Path: an accepted req beat passes registers s1 to s6 to become its rsp beat.
// One beat per cycle unless rsp_stall; stages stall singly so bubbles collapse.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps

module hsl_to_rgb_converter import hsl2rgb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [CH_W-1:0] req_hue,
   input  logic [CH_W-1:0] req_saturation,
   input  logic [CH_W-1:0] req_lightness,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CH_W-1:0] rsp_red,
   output logic [CH_W-1:0] rsp_green,
   output logic [CH_W-1:0] rsp_blue
);

   hsl2rgb_en_type  en;
   logic [QW-1:0]   p_s3, d_s3;
   logic [FX_W-1:0] t_red, t_green, t_blue;
   logic            grey_s3;
   logic [CH_W-1:0] light_s3;

   hsl2rgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .en        (en)
   );

   hsl2rgb_front u_front (
      .clock          (clock),
      .en             (en),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .p_out          (p_s3),
      .d_out          (d_s3),
      .t_red          (t_red),
      .t_green        (t_green),
      .t_blue         (t_blue),
      .grey_out       (grey_s3),
      .light_out      (light_s3)
   );

   hsl2rgb_lane u_lane_red (
      .clock    (clock),
      .en       (en),
      .p_in     (p_s3),
      .d_in     (d_s3),
      .t_in     (t_red),
      .grey_in  (grey_s3),
      .light_in (light_s3),
      .ch_out   (rsp_red)
   );

   hsl2rgb_lane u_lane_green (
      .clock    (clock),
      .en       (en),
      .p_in     (p_s3),
      .d_in     (d_s3),
      .t_in     (t_green),
      .grey_in  (grey_s3),
      .light_in (light_s3),
      .ch_out   (rsp_green)
   );

   hsl2rgb_lane u_lane_blue (
      .clock    (clock),
      .en       (en),
      .p_in     (p_s3),
      .d_in     (d_s3),
      .t_in     (t_blue),
      .grey_in  (grey_s3),
      .light_in (light_s3),
      .ch_out   (rsp_blue)
   );

endmodule

// File: sv/hsl2rgb_checker.sv
// Port-level assertions for the HSL to RGB converter and their bind.
`timescale 1ns / 1ps

module hsl2rgb_checker import hsl2rgb_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic [CH_W-1:0] req_saturation,
   input logic [CH_W-1:0] req_lightness,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input logic [CH_W-1:0] rsp_red,
   input logic [CH_W-1:0] rsp_green,
   input logic [CH_W-1:0] rsp_blue
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("rsp payload changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty output");

   a_grey_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_saturation == '0) ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid && rsp_red == $past(req_lightness, 6)
          && rsp_green == $past(req_lightness, 6) && rsp_blue == $past(req_lightness, 6))
      else $error("grey beat wrong or late");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_checker (.*);

// File: test/hsl_to_rgb_converter_check.sv
// Checker for the HSL to RGB converter: predicts each color and compares the rsp beats.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_check import hsl2rgb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  logic [CH_W-1:0] req_hue,
   input  logic [CH_W-1:0] req_saturation,
   input  logic [CH_W-1:0] req_lightness,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  logic [CH_W-1:0] rsp_red,
   input  logic [CH_W-1:0] rsp_green,
   input  logic [CH_W-1:0] rsp_blue,
   output int              mismatches,
   output int              pending_beats
);

   localparam longint unsigned UNIT       = 64'd1 << FRAC_BITS;
   localparam longint unsigned UNIT_HALF  = UNIT / 2;
   localparam longint unsigned UNIT_THIRD = UNIT / 3;
   localparam longint unsigned UNIT_SIXTH = UNIT / 6;
   localparam longint unsigned UNIT_2_3   = (2 * UNIT) / 3;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } color_type;

   color_type want_q[$];

   function automatic longint unsigned to_unit(input logic [CH_W-1:0] v);
      longint unsigned wide;
      wide = longint'(v);
      return (wide * UNIT) / 255;
   endfunction

   function automatic longint unsigned hue_ramp(input longint unsigned p, input longint unsigned q,
                                                input longint unsigned t);
      longint unsigned span;
      span = q - p;
      if (t < UNIT_SIXTH) begin
         return p + ((span * 6 * t) >> FRAC_BITS);
      end
      if (t < UNIT_HALF) begin
         return q;
      end
      if (t < UNIT_2_3) begin
         return p + ((span * 6 * (UNIT_2_3 - t)) >> FRAC_BITS);
      end
      return p;
   endfunction

   function automatic logic [CH_W-1:0] to_level(input longint unsigned v);
      longint unsigned lvl;
      lvl = (v * 255) >> FRAC_BITS;
      if (lvl > 255) begin
         lvl = 255;
      end
      return CH_W'(lvl);
   endfunction

   function automatic color_type hsl_color(input logic [CH_W-1:0] h, input logic [CH_W-1:0] s,
                                           input logic [CH_W-1:0] l);
      color_type       c;
      longint unsigned hf, sf, lf, m, q, p, t_red, t_blue;
      if (s == '0) begin
         c.red   = l;
         c.green = l;
         c.blue  = l;
         return c;
      end
      hf = to_unit(h);
      sf = to_unit(s);
      lf = to_unit(l);
      m  = (lf * sf) >> FRAC_BITS;
      q  = (lf < UNIT_HALF) ? lf + m : lf + sf - m;
      p  = (2 * lf > q) ? 2 * lf - q : 0;
      if (q < p) begin
         q = p;
      end
      t_red = hf + UNIT_THIRD;
      if (t_red > UNIT) begin
         t_red = t_red - UNIT;
      end
      t_blue  = (hf < UNIT_THIRD) ? hf + UNIT - UNIT_THIRD : hf - UNIT_THIRD;
      c.red   = to_level(hue_ramp(p, q, t_red));
      c.green = to_level(hue_ramp(p, q, hf));
      c.blue  = to_level(hue_ramp(p, q, t_blue));
      return c;
   endfunction

   task automatic report(input string field, input logic [CH_W-1:0] want,
                         input logic [CH_W-1:0] got);
      mismatches = mismatches + 1;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   initial begin
      mismatches    = 0;
      pending_beats = 0;
   end

   always @(posedge clock) begin
      color_type want;
      if (reset) begin
         want_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (want_q.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: expected no rsp beat, got r=%0d g=%0d b=%0d", $time,
                        rsp_red, rsp_green, rsp_blue);
            end else begin
               want = want_q.pop_front();
               if (rsp_red !== want.red) begin
                  report("red", want.red, rsp_red);
               end
               if (rsp_green !== want.green) begin
                  report("green", want.green, rsp_green);
               end
               if (rsp_blue !== want.blue) begin
                  report("blue", want.blue, rsp_blue);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want_q.push_back(hsl_color(req_hue, req_saturation, req_lightness));
         end
      end
      pending_beats <= want_q.size();
   end

endmodule

// File: test/hsl_to_rgb_converter_test.sv
// Testbench top for the HSL to RGB converter: clock, reset, req and rsp traffic, verdict.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test import hsl2rgb_pkg::*;;

   localparam int RANDOM_BEATS = 1050;
   localparam int DRAIN_AT     = 800;
   localparam int IDLE_PCT     = 28;

   logic            clock          = 1'b0;
   logic            reset          = 1'b1;
   logic            req_valid      = 1'b0;
   logic            req_stall;
   logic [CH_W-1:0] req_hue        = '0;
   logic [CH_W-1:0] req_saturation = '0;
   logic [CH_W-1:0] req_lightness  = '0;
   logic            rsp_valid;
   logic            rsp_stall      = 1'b0;
   logic [CH_W-1:0] rsp_red;
   logic [CH_W-1:0] rsp_green;
   logic [CH_W-1:0] rsp_blue;
   int              mismatch_count;
   int              pending_beats;

   // hue, saturation, lightness
   logic [23:0] corners [0:23] = '{
      24'h00_00_00, 24'hFF_FF_FF, 24'h00_FF_80, 24'h00_FF_7F, 24'hFF_00_FF, 24'h00_00_4D,
      24'h80_00_FF, 24'h55_FF_80, 24'hAA_FF_80, 24'h2B_FF_80, 24'h80_FF_80, 24'hFF_FF_80,
      24'h01_01_01, 24'hFE_FE_FE, 24'h2A_C0_40, 24'hD5_40_C0, 24'h00_FF_FF, 24'h00_FF_00,
      24'h7F_80_7F, 24'h00_01_80, 24'hFF_FF_01, 24'h15_FF_80, 24'hAB_80_20, 24'h1C_E6_B4
   };

   hsl_to_rgb_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   hsl_to_rgb_converter_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .mismatches     (mismatch_count),
      .pending_beats  (pending_beats)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [CH_W-1:0] pick_field(input int mode);
      logic [1:0] sel;
      sel = 2'($urandom_range(3));
      if (mode != 1) begin
         return CH_W'($urandom_range(255));
      end
      case (sel)
         2'd0: return 8'd0;
         2'd1: return 8'd127;
         2'd2: return 8'd128;
         default: return 8'd255;
      endcase
   endfunction

   task automatic send_pixel(input logic [23:0] hsl, input bit quiet);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_hue        <= hsl[23:16];
      req_saturation <= hsl[15:8];
      req_lightness  <= hsl[7:0];
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_beats == 0);
      @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off to fill the pipe, then a stall-free stretch
   initial begin
      int cyc;
      cyc = 0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (cyc >= 400 && cyc < 460) begin
            rsp_stall <= 1'b1;
         end else if (cyc >= 460 && cyc < 700) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
         @(posedge clock);
         cyc = cyc + 1;
      end
   end

   initial begin
      int          mode;
      logic [23:0] hsl;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (corners[i]) begin
         send_pixel(corners[i], 1'b0);
      end
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         mode = $urandom_range(7);
         hsl  = {pick_field(mode), pick_field(mode), pick_field(mode)};
         if (mode == 0) begin
            hsl[15:8] = 8'd0;
         end
         send_pixel(hsl, i >= 300 && i < 500);
         if (i == DRAIN_AT) begin
            drain_pipe();
         end
      end
      drain_pipe();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("hsl_to_rgb_converter_test: done, clean");
      end else begin
         $display("hsl_to_rgb_converter_test: done, errors");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("hsl_to_rgb_converter_test: done, errors");
      $finish;
   end

endmodule

// File: files.f
sv/hsl2rgb_pkg.sv
sv/hsl2rgb_ctrl.sv
sv/hsl2rgb_front.sv
sv/hsl2rgb_lane.sv
sv/hsl_to_rgb_converter.sv
sv/hsl2rgb_checker.sv
test/hsl_to_rgb_converter_check.sv
test/hsl_to_rgb_converter_test.sv
